>>> rtl/lppc_pkg.sv
// Shared constants, codes and types for the layered pixel plane compositor.
// Depends on nothing; lppc_clear, lppc_merge, the top level and the testbench use it.
`default_nettype none
package lppc_pkg;

  localparam int LAYERS = 4;
  localparam int WIDTH  = 512;
  localparam int HEIGHT = 512;

  localparam int WORD_W  = 32;
  localparam int ROW_W   = LAYERS * WORD_W;
  localparam int X_W     = 9;
  localparam int Y_W     = 9;
  localparam int LAYER_W = 3;
  localparam int PIX_AW  = X_W + Y_W;
  localparam int DEPTH   = 1 << PIX_AW;
  localparam int SUM_W   = 13;
  localparam int ADDR_W  = 26;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 14;
  localparam int HALF_BITS = 16;

  localparam logic [WORD_W-1:0] HALF_MASK = 32'h0000_FFFF;

  localparam logic KIND_PUT    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [CFG_IW-1:0] REG_X_OFFSET    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_Y_OFFSET    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_PIXEL_BYTES = 2'd2;
  localparam logic [CFG_IW-1:0] REG_LINE_LENGTH = 2'd3;

  localparam logic [11:0] X_OFFSET_RST    = 12'd0;
  localparam logic [11:0] Y_OFFSET_RST    = 12'd0;
  localparam logic [2:0]  PIXEL_BYTES_RST = 3'd4;
  localparam logic [13:0] LINE_LENGTH_RST = 14'd2048;

  typedef struct packed {
    logic               kind;
    logic               err;
    logic               store_en;
    logic [LAYER_W-1:0] layer;
    logic [WORD_W-1:0]  color;
    logic [SUM_W-1:0]   x_sum;
    logic [SUM_W-1:0]   y_sum;
  } req_t;

  typedef struct packed {
    logic              active;
    logic [PIX_AW-1:0] addr;
  } clr_t;

endpackage
`default_nettype wire

>>> rtl/lppc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; width and depth come from its parameters.
`default_nettype none
module lppc_ram #(
  parameter int WIDTH_P = 32,
  parameter int DEPTH_P = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  wire logic [WIDTH_P-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output logic      [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/lppc_clear.sv
// Clearing sweep that zeroes the layer memory one row per cycle after reset.
// Depends on lppc_pkg.
`default_nettype none
module lppc_clear
  import lppc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  output clr_t      clr_o
);

  logic              active_q, active_d;
  logic [PIX_AW-1:0] cnt_q, cnt_d;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      cnt_d = cnt_q + PIX_AW'(1);
      if (&cnt_q) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign clr_o.active = active_q;
  assign clr_o.addr   = cnt_q;

endmodule
`default_nettype wire

>>> rtl/lppc_merge.sv
// Row update and topmost-layer selection for one pixel of the layer memory.
// Depends on lppc_pkg.
`default_nettype none
module lppc_merge
  import lppc_pkg::*;
(
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire req_t              req_i,
  output logic      [ROW_W-1:0]  row_o,
  output logic      [WORD_W-1:0] color_o
);

  logic [WORD_W-1:0] word;

  always_comb begin
    row_o   = row_i;
    color_o = req_i.color;
    for (int l = 0; l < LAYERS; l++) begin
      word = row_i[l*WORD_W +: WORD_W];
      if (LAYER_W'(l) == req_i.layer) begin
        word = (req_i.kind == KIND_PUT) ? req_i.color : '0;
      end
      row_o[l*WORD_W +: WORD_W] = word;
      if (req_i.store_en && (word != '0)) begin
        color_o = word;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/layered_pixel_plane_compositor.sv
// Layered pixel plane compositor: top level with control, memory and address logic.
// The start word and the row read from the layer memory are registered, then the result word is registered.
// A new word is not taken while the read-modify-write of the layer memory is under way; busy is high then.
// Reset: a sweep zeroes all 262144 rows of the layer memory, busy is high throughout it.
// Results cannot be stalled: each is shown for one cycle with done_o.
// Depends on lppc_pkg, lppc_ram, lppc_clear and lppc_merge.
`default_nettype none
module layered_pixel_plane_compositor
  import lppc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind_i,
  input  wire logic [X_W-1:0]     x_pos_i,
  input  wire logic [Y_W-1:0]     y_pos_i,
  input  wire logic               has_layer_i,
  input  wire logic [LAYER_W-1:0] layer_i,
  input  wire logic [WORD_W-1:0]  color_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_IW-1:0]  cfg_index_i,
  input  wire logic [CFG_DW-1:0]  cfg_data_i,
  output logic                    done_o,
  output logic                    write_valid_o,
  output logic      [ADDR_W-1:0]  write_address_o,
  output logic      [WORD_W-1:0]  write_data_o,
  output logic                    half_word_o,
  output logic                    layer_error_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  logic        state_q, state_d;
  logic [11:0] x_offset_q;
  logic [11:0] y_offset_q;
  logic [2:0]  pixel_bytes_q;
  logic [13:0] line_length_q;

  req_t              req_q, req_d;
  clr_t              clr;
  logic              accept;
  logic              in_plane;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  new_row;
  logic [WORD_W-1:0] top_color;
  logic              ram_we;
  logic [PIX_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [PIX_AW-1:0] ram_raddr_q;
  logic [15:0]       x_prod;
  logic [26:0]       y_prod;
  logic [ADDR_W-1:0] addr;
  logic              half;

  logic              done_q, done_d;
  logic              wvalid_q, wvalid_d;
  logic [ADDR_W-1:0] waddr_q, waddr_d;
  logic [WORD_W-1:0] wdata_q, wdata_d;
  logic              half_q, half_d;
  logic              lerr_q, lerr_d;

  lppc_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  assign busy   = clr.active | (state_q == ST_RMW);
  assign accept = start & ~busy;

  always_comb begin
    in_plane       = (32'(x_pos_i) < 32'(WIDTH)) && (32'(y_pos_i) < 32'(HEIGHT));
    req_d          = req_q;
    state_d        = state_q;
    if (accept) begin
      req_d.kind     = kind_i;
      req_d.err      = has_layer_i && (32'(layer_i) >= 32'(LAYERS));
      req_d.store_en = has_layer_i && in_plane;
      req_d.layer    = layer_i;
      req_d.color    = ((kind_i == KIND_PUT) && (color_i == '0)) ? WORD_W'(1) : color_i;
      req_d.x_sum    = SUM_W'(x_pos_i) + SUM_W'(x_offset_q);
      req_d.y_sum    = SUM_W'(y_pos_i) + SUM_W'(y_offset_q);
      state_d        = ST_RMW;
    end else if (state_q == ST_RMW) begin
      state_d = ST_IDLE;
    end
  end

  lppc_ram #(
    .WIDTH_P (ROW_W),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({x_pos_i, y_pos_i}),
    .rdata_o (rd_row)
  );

  lppc_merge u_merge (
    .row_i   (rd_row),
    .req_i   (req_q),
    .row_o   (new_row),
    .color_o (top_color)
  );

  always_comb begin
    if (clr.active) begin
      ram_we    = 1'b1;
      ram_waddr = clr.addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_RMW) && req_q.store_en && !req_q.err;
      ram_waddr = ram_raddr_q;
      ram_wdata = new_row;
    end
  end

  always_comb begin
    x_prod   = 16'(req_q.x_sum) * 16'(pixel_bytes_q);
    y_prod   = 27'(req_q.y_sum) * 27'(line_length_q);
    addr     = ADDR_W'(x_prod) + y_prod[ADDR_W-1:0];
    half     = (pixel_bytes_q == 3'd2);
    done_d   = (state_q == ST_RMW);
    wvalid_d = !req_q.err;
    lerr_d   = req_q.err;
    half_d   = !req_q.err && half;
    waddr_d  = req_q.err ? '0 : addr;
    if (req_q.err) begin
      wdata_d = '0;
    end else if (half) begin
      wdata_d = top_color & HALF_MASK;
    end else begin
      wdata_d = top_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      done_q        <= 1'b0;
      x_offset_q    <= X_OFFSET_RST;
      y_offset_q    <= Y_OFFSET_RST;
      pixel_bytes_q <= PIXEL_BYTES_RST;
      line_length_q <= LINE_LENGTH_RST;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_X_OFFSET:    x_offset_q    <= cfg_data_i[11:0];
          REG_Y_OFFSET:    y_offset_q    <= cfg_data_i[11:0];
          REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[2:0];
          REG_LINE_LENGTH: line_length_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (accept) begin
      ram_raddr_q <= {x_pos_i, y_pos_i};
    end
    wvalid_q <= wvalid_d;
    waddr_q  <= waddr_d;
    wdata_q  <= wdata_d;
    half_q   <= half_d;
    lerr_q   <= lerr_d;
  end

  assign done_o          = done_q;
  assign write_valid_o   = wvalid_q;
  assign write_address_o = waddr_q;
  assign write_data_o    = wdata_q;
  assign half_word_o     = half_q;
  assign layer_error_o   = lerr_q;

endmodule
`default_nettype wire

>>> test/layered_pixel_plane_compositor_tb.sv
// Self-checking testbench for the layered pixel plane compositor: directed rows, then
// random put, remove and direct words across several register settings.
// Depends on lppc_pkg and the layered_pixel_plane_compositor top level.
`timescale 1ns / 100ps
module layered_pixel_plane_compositor_tb;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 117;
  localparam int HOT_PIXELS = 6;
  localparam int DIRECTED_ROWS = 17;

  typedef struct packed {
    logic                               kind;
    logic [lppc_pkg::X_W-1:0]           x;
    logic [lppc_pkg::Y_W-1:0]           y;
    logic                               has_layer;
    logic [lppc_pkg::LAYER_W-1:0]       layer;
    logic [lppc_pkg::WORD_W-1:0]        color;
  } pixel_req_t;

  typedef struct packed {
    logic                               valid;
    logic [lppc_pkg::ADDR_W-1:0]        addr;
    logic [lppc_pkg::WORD_W-1:0]        data;
    logic                               half;
    logic                               err;
  } fb_write_t;

  typedef struct packed {
    pixel_req_t req;
    logic       typed;
    fb_write_t  want;
  } row_t;

  localparam logic PUT = lppc_pkg::KIND_PUT;
  localparam logic REM = lppc_pkg::KIND_REMOVE;

  // Rows with typed results assume the register values after reset.
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{PUT, 9'd0,   9'd0,   1'b1, 3'd0, 32'h0000_0000}, 1'b1,
      '{1'b1, 26'h0,     32'h0000_0001, 1'b0, 1'b0}},
    '{'{PUT, 9'd0,   9'd0,   1'b1, 3'd3, 32'hFFFF_FFFF}, 1'b1,
      '{1'b1, 26'h0,     32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{'{PUT, 9'd0,   9'd0,   1'b1, 3'd1, 32'h1234_5678}, 1'b0, '0},
    '{'{REM, 9'd0,   9'd0,   1'b1, 3'd3, 32'h0000_AAAA}, 1'b0, '0},
    '{'{REM, 9'd0,   9'd0,   1'b1, 3'd1, 32'h0000_0000}, 1'b0, '0},
    '{'{REM, 9'd0,   9'd0,   1'b1, 3'd0, 32'hCAFE_F00D}, 1'b1,
      '{1'b1, 26'h0,     32'hCAFE_F00D, 1'b0, 1'b0}},
    '{'{PUT, 9'd511, 9'd511, 1'b1, 3'd3, 32'hFFFF_FFFF}, 1'b1,
      '{1'b1, 26'hFFFFC, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{'{REM, 9'd511, 9'd511, 1'b1, 3'd2, 32'h0000_0005}, 1'b0, '0},
    '{'{PUT, 9'd511, 9'd0,   1'b0, 3'd0, 32'h0000_0000}, 1'b1,
      '{1'b1, 26'h7FC,   32'h0000_0001, 1'b0, 1'b0}},
    '{'{REM, 9'd0,   9'd511, 1'b0, 3'd0, 32'h0000_0000}, 1'b1,
      '{1'b1, 26'hFF800, 32'h0000_0000, 1'b0, 1'b0}},
    '{'{PUT, 9'd5,   9'd5,   1'b1, 3'd4, 32'h0000_0011}, 1'b1,
      '{1'b0, 26'h0,     32'h0,         1'b0, 1'b1}},
    '{'{REM, 9'd5,   9'd5,   1'b1, 3'd7, 32'h0000_0011}, 1'b1,
      '{1'b0, 26'h0,     32'h0,         1'b0, 1'b1}},
    '{'{PUT, 9'd511, 9'd511, 1'b1, 3'd5, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 26'h0,     32'h0,         1'b0, 1'b1}},
    '{'{PUT, 9'd1,   9'd1,   1'b0, 3'd7, 32'h0000_FFFF}, 1'b1,
      '{1'b1, 26'h804,   32'h0000_FFFF, 1'b0, 1'b0}},
    '{'{PUT, 9'd256, 9'd128, 1'b1, 3'd2, 32'h8000_0000}, 1'b0, '0},
    '{'{REM, 9'd256, 9'd128, 1'b1, 3'd2, 32'h7FFF_FFFF}, 1'b0, '0},
    '{'{REM, 9'd511, 9'd511, 1'b1, 3'd3, 32'h0000_0000}, 1'b1,
      '{1'b1, 26'hFFFFC, 32'h0000_0000, 1'b0, 1'b0}}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic                              kind_i;
  logic [lppc_pkg::X_W-1:0]          x_pos_i;
  logic [lppc_pkg::Y_W-1:0]          y_pos_i;
  logic                              has_layer_i;
  logic [lppc_pkg::LAYER_W-1:0]      layer_i;
  logic [lppc_pkg::WORD_W-1:0]       color_i;
  logic                              cfg_we_i;
  logic [lppc_pkg::CFG_IW-1:0]       cfg_index_i;
  logic [lppc_pkg::CFG_DW-1:0]       cfg_data_i;
  logic                              done_o;
  logic                              write_valid_o;
  logic [lppc_pkg::ADDR_W-1:0]       write_address_o;
  logic [lppc_pkg::WORD_W-1:0]       write_data_o;
  logic                              half_word_o;
  logic                              layer_error_o;

  logic [11:0] cur_x_offset;
  logic [11:0] cur_y_offset;
  logic [2:0]  cur_pixel_bytes;
  logic [13:0] cur_line_length;

  logic [31:0] pixel_layers [int unsigned];
  fb_write_t   pending_writes [$];
  int          mismatches;
  int          cycle_count;

  layered_pixel_plane_compositor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .x_pos_i         (x_pos_i),
    .y_pos_i         (y_pos_i),
    .has_layer_i     (has_layer_i),
    .layer_i         (layer_i),
    .color_i         (color_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .write_valid_o   (write_valid_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .half_word_o     (half_word_o),
    .layer_error_o   (layer_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic fb_write_t compose_pixel(pixel_req_t r);
    fb_write_t         w;
    logic [31:0]       c;
    longint unsigned   a;
    int unsigned       key;
    logic [2:0]        lyr;
    int                l;
    logic              found;
    w = '0;
    if (r.has_layer && r.layer >= lppc_pkg::LAYERS) begin
      w.err = 1'b1;
      return w;
    end
    c = r.color;
    if (r.kind == lppc_pkg::KIND_PUT && c == 32'h0) c = 32'h1;
    if (r.has_layer) begin
      key = 32'({r.layer, r.x, r.y});
      if (r.kind == lppc_pkg::KIND_PUT) pixel_layers[key] = c;
      else pixel_layers.delete(key);
      found = 1'b0;
      for (l = lppc_pkg::LAYERS - 1; l >= 0 && !found; l--) begin
        lyr = l[2:0];
        key = 32'({lyr, r.x, r.y});
        if (pixel_layers.exists(key)) begin
          c = pixel_layers[key];
          found = 1'b1;
        end
      end
    end
    a = (64'(r.x) + 64'(cur_x_offset)) * 64'(cur_pixel_bytes)
      + (64'(r.y) + 64'(cur_y_offset)) * 64'(cur_line_length);
    w.valid = 1'b1;
    w.addr  = a[lppc_pkg::ADDR_W-1:0];
    w.half  = (cur_pixel_bytes == 3'd2);
    w.data  = w.half ? (c & lppc_pkg::HALF_MASK) : c;
    return w;
  endfunction

  task automatic send_pixel(pixel_req_t r, logic typed, fb_write_t want);
    fb_write_t w;
    start       <= 1'b1;
    kind_i      <= r.kind;
    x_pos_i     <= r.x;
    y_pos_i     <= r.y;
    has_layer_i <= r.has_layer;
    layer_i     <= r.layer;
    color_i     <= r.color;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    w = compose_pixel(r);
    pending_writes.push_back(typed ? want : w);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_registers(logic [13:0] xd, logic [13:0] yd, logic [13:0] pd,
                                logic [13:0] ld);
    logic [13:0] data [4];
    int          i;
    data = '{xd, yd, pd, ld};
    for (i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= i[lppc_pkg::CFG_IW-1:0];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      case (i[lppc_pkg::CFG_IW-1:0])
        lppc_pkg::REG_X_OFFSET:    cur_x_offset    = data[i][11:0];
        lppc_pkg::REG_Y_OFFSET:    cur_y_offset    = data[i][11:0];
        lppc_pkg::REG_PIXEL_BYTES: cur_pixel_bytes = data[i][2:0];
        lppc_pkg::REG_LINE_LENGTH: cur_line_length = data[i][13:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic pixel_req_t random_pixel(logic [8:0] hx [HOT_PIXELS],
                                              logic [8:0] hy [HOT_PIXELS]);
    pixel_req_t r;
    int         h;
    int         pick;
    r.kind = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 80) begin
      h   = $urandom_range(0, HOT_PIXELS - 1);
      r.x = hx[h];
      r.y = hy[h];
    end else begin
      r.x = 9'($urandom_range(0, 511));
      r.y = 9'($urandom_range(0, 511));
    end
    r.has_layer = ($urandom_range(0, 99) < 90);
    if (r.has_layer && $urandom_range(0, 99) < 88) r.layer = 3'($urandom_range(0, 3));
    else r.layer = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.color = 32'h0;
    else if (pick == 1) r.color = 32'hFFFF_FFFF;
    else r.color = $urandom;
    return r;
  endfunction

  always @(posedge clk_i) begin
    fb_write_t got;
    fb_write_t exp;
    got = '{write_valid_o, write_address_o, write_data_o, half_word_o, layer_error_o};
    if (rst_ni && done_o) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: write word with none expected: valid %0b addr %h data %h half %0b err %0b",
                 $time, got.valid, got.addr, got.data, got.half, got.err);
        mismatches++;
      end else begin
        exp = pending_writes.pop_front();
        if (got !== exp) begin
          $display("%0t: expected valid %0b addr %h data %h half %0b err %0b", $time,
                   exp.valid, exp.addr, exp.data, exp.half, exp.err);
          $display("%0t: actual   valid %0b addr %h data %h half %0b err %0b", $time,
                   got.valid, got.addr, got.data, got.half, got.err);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [8:0]  hot_x [HOT_PIXELS];
    logic [8:0]  hot_y [HOT_PIXELS];
    logic [2:0]  phase_bytes [PHASES];
    pixel_req_t  r;
    int          phase;
    int          i;
    int          h;
    int          roll;
    int          burst_left;
    phase_bytes     = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd1, 3'd3, 3'd6, 3'd5};
    mismatches      = 0;
    cycle_count     = 0;
    burst_left      = 0;
    cur_x_offset    = lppc_pkg::X_OFFSET_RST;
    cur_y_offset    = lppc_pkg::Y_OFFSET_RST;
    cur_pixel_bytes = lppc_pkg::PIXEL_BYTES_RST;
    cur_line_length = lppc_pkg::LINE_LENGTH_RST;
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = lppc_pkg::KIND_PUT;
    x_pos_i     = '0;
    y_pos_i     = '0;
    has_layer_i = 1'b0;
    layer_i     = '0;
    color_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = lppc_pkg::REG_X_OFFSET;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_pixel(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
      if (i % 3 == 2) hold_off($urandom_range(1, 5));
    end

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_writes();
        if (phase == 1) load_registers(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        else if (phase_bytes[phase] == 3'd0) load_registers('0, '0, '0, '0);
        else load_registers(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                            {11'($urandom_range(0, 2047)), phase_bytes[phase]},
                            14'($urandom_range(0, 16383)));
      end
      for (h = 0; h < HOT_PIXELS; h++) begin
        hot_x[h] = 9'($urandom_range(0, 511));
        hot_y[h] = 9'($urandom_range(0, 511));
      end
      hot_x[0] = 9'd0;
      hot_y[0] = 9'd511;
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        r = random_pixel(hot_x, hot_y);
        send_pixel(r, 1'b0, '0);
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          roll = $urandom_range(0, 999);
          if (roll < 30) burst_left = $urandom_range(15, 40);
          else if (roll < 45) drain_writes();
          else if (roll < 450) ;
          else if (roll < 850) hold_off($urandom_range(1, 3));
          else if (roll < 970) hold_off($urandom_range(4, 10));
          else hold_off($urandom_range(20, 60));
        end
      end
    end

    drain_writes();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
